/* rtl/jsu_pkg.sv */
// Shared types, codes and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

	// token modes
	localparam logic [1:0] KIND_ESCAPE = 2'd0;
	localparam logic [1:0] KIND_COPY   = 2'd1;

	// escape phases
	localparam logic [2:0] PH_NORMAL    = 3'd0;
	localparam logic [2:0] PH_BACKSLASH = 3'd1;
	localparam logic [2:0] PH_HEX0      = 3'd2;
	localparam logic [2:0] PH_HEX3      = 3'd5;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] code_point;
		logic [2:0][7:0] held;
	} jsu_state_t;

	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
	} jsu_result_t;

	function automatic logic [7:0] map_escape(input logic [7:0] c);
		case (c)
			8'h62:   map_escape = 8'h08; // b
			8'h66:   map_escape = 8'h0C; // f
			8'h6E:   map_escape = 8'h0A; // n
			8'h72:   map_escape = 8'h0D; // r
			8'h74:   map_escape = 8'h09; // t
			default: map_escape = c;
		endcase
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end
		hex_value = d[3:0];
	endfunction

endpackage

/* rtl/jsu_decode.sv */
// Per-byte decode: next escape state and the up to three result bytes.
`timescale 1ns / 1ps

module jsu_decode (
	input  logic [1:0]          kind,
	input  logic [7:0]          in_byte,
	input  logic                token_last,
	input  jsu_pkg::jsu_state_t cur,
	output jsu_pkg::jsu_state_t nxt,
	output jsu_pkg::jsu_result_t res
);
	import jsu_pkg::*;

	always_comb begin
		logic [1:0]  n;
		logic [1:0]  k;
		logic [2:0]  k_wide;
		logic [15:0] cp;
		logic [7:0]  b0;
		logic [7:0]  b1;
		n      = 2'd0;
		nxt    = cur;
		res    = '0;
		k_wide = cur.phase - PH_HEX0;
		k      = (k_wide > 3'd3) ? 2'd3 : k_wide[1:0];
		cp     = {cur.code_point[11:0], hex_value(in_byte)};
		b0     = cur.held[0];
		b1     = cur.held[1];

		if (kind != KIND_ESCAPE) begin
			nxt.phase = PH_NORMAL;
			if (kind == KIND_COPY) begin
				res.bytes[n] = in_byte; n = n + 2'd1;
			end
		end else if (cur.phase == PH_NORMAL) begin
			if (in_byte == CH_BACKSLASH && !token_last) begin
				nxt.phase = PH_BACKSLASH;
			end else begin
				res.bytes[n] = in_byte; n = n + 2'd1;
			end
		end else if (cur.phase == PH_BACKSLASH) begin
			if (in_byte == CH_U) begin
				nxt.phase      = PH_HEX0;
				nxt.code_point = '0;
			end else begin
				res.bytes[n] = map_escape(in_byte); n = n + 2'd1;
				nxt.phase    = PH_NORMAL;
			end
		end else begin
			nxt.code_point = cp;
			if (k == 2'd3) begin
				nxt.phase = PH_NORMAL;
				if (cp < 16'h0080) begin
					res.bytes[n] = cp[7:0]; n = n + 2'd1;
				end else if (cp < 16'h0800) begin
					res.bytes[n] = 8'hC0 | {3'b000, cp[10:6]}; n = n + 2'd1;
					res.bytes[n] = 8'h80 | {2'b00, cp[5:0]};   n = n + 2'd1;
				end else begin
					res.bytes[n] = 8'hE0 | {4'h0, cp[15:12]}; n = n + 2'd1;
					res.bytes[n] = 8'h80 | {2'b00, cp[11:6]}; n = n + 2'd1;
					res.bytes[n] = 8'h80 | {2'b00, cp[5:0]};  n = n + 2'd1;
				end
			end else begin
				nxt.held[k] = in_byte;
				nxt.phase   = cur.phase + 3'd1;
				if (token_last) begin
					// cut-short \u: rescan held digits plus this byte as plain text
					case (k)
						2'd0: begin
							res.bytes[n] = in_byte; n = n + 2'd1;
						end
						2'd1: begin
							if (b0 == CH_BACKSLASH) begin
								if (in_byte != CH_U) begin
									res.bytes[n] = map_escape(in_byte); n = n + 2'd1;
								end
							end else begin
								res.bytes[n] = b0;      n = n + 2'd1;
								res.bytes[n] = in_byte; n = n + 2'd1;
							end
						end
						default: begin
							if (b0 == CH_BACKSLASH) begin
								if (b1 != CH_U) begin
									res.bytes[n] = map_escape(b1); n = n + 2'd1;
								end
								res.bytes[n] = in_byte; n = n + 2'd1;
							end else begin
								res.bytes[n] = b0; n = n + 2'd1;
								if (b1 == CH_BACKSLASH) begin
									if (in_byte != CH_U) begin
										res.bytes[n] = map_escape(in_byte); n = n + 2'd1;
									end
								end else begin
									res.bytes[n] = b1;      n = n + 2'd1;
									res.bytes[n] = in_byte; n = n + 2'd1;
								end
							end
						end
					endcase
				end
			end
		end

		if (token_last) begin
			nxt.phase = PH_NORMAL;
		end
		res.count = n;
	end

endmodule

/* rtl/jsu_outbuf.sv */
// Result register: holds up to three decoded bytes and drains one per cycle while out_ready is high.
`timescale 1ns / 1ps

module jsu_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  jsu_pkg::jsu_result_t load_res,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last
);
	import jsu_pkg::*;

	logic [1:0]      cnt_q;
	logic [2:0][7:0] buf_q;
	logic            pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign out_byte  = buf_q[0];
	assign run_last  = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_res.bytes;
		end else if (pop) begin
			buf_q <= {8'h00, buf_q[2], buf_q[1]};
		end
	end

endmodule

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper: escape state and result buffer.
`timescale 1ns / 1ps
// Latency: the first result byte of an item is valid the cycle after the item is accepted.
// Throughput: one item per cycle while items make at most one byte and out_ready is
//   high; an item that makes two or three bytes (UTF-8 from \u, truncated \u tail)
//   holds the input until the result buffer is draining its last byte.
// Reset (arst_n low, asynchronous): escape phase to normal, code point to zero,
//   result buffer empty. Held digit bytes are not reset.

module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] in_byte,
	input  logic       token_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import jsu_pkg::*;

	// escape state carried between bytes of a token
	logic [2:0]      phase_q;
	logic [15:0]     code_point_q;
	logic [2:0][7:0] held_q;      // raw \u digits, only read once written

	jsu_state_t  cur;
	jsu_state_t  nxt;
	jsu_result_t res;
	logic        in_fire;

	assign cur.phase      = phase_q;
	assign cur.code_point = code_point_q;
	assign cur.held       = held_q;

	// the buffer takes a new item when empty or when its last byte leaves now
	assign in_fire = in_valid && in_ready;

	jsu_decode u_decode (
		.kind       (kind),
		.in_byte    (in_byte),
		.token_last (token_last),
		.cur        (cur),
		.nxt        (nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_NORMAL;
			code_point_q <= '0;
		end else if (in_fire) begin
			phase_q      <= nxt.phase;
			code_point_q <= nxt.code_point;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= nxt.held;
		end
	end

	// result register; an item that makes no byte simply leaves it empty
	jsu_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.load_res  (res),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

/* dv/json_string_unescape_utf8_test.sv */
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
	import jsu_pkg::*;

	// modes the package leaves unnamed; both of them discard the byte
	localparam logic [1:0] KIND_DROP  = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int RandomItems = 120;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       tok_end;
	} src_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
	} dec_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_COPY;
	logic [7:0] in_byte = 8'h00;
	logic       token_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.in_byte(in_byte),
		.token_last(token_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	src_item_t raw_feed[$];     // source bytes not yet offered to the block
	dec_byte_t decoded_due[$];  // decoded bytes predicted but not yet seen
	int        mismatches = 0;

	// predictor copy of the unescaper state
	logic [2:0]  esc_phase = PH_NORMAL;
	logic [15:0] cp_acc = 16'h0000;
	logic [7:0]  digit_buf[3];

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// simple escapes; anything unlisted stands for itself
	function automatic logic [7:0] unescape_char(input logic [7:0] c);
		case (c)
			"n":     return 8'h0A;
			"t":     return 8'h09;
			"r":     return 8'h0D;
			"b":     return 8'h08;
			"f":     return 8'h0C;
			default: return c;
		endcase
	endfunction

	// non-hex characters weigh zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= "A" && c <= "F") begin
			v = c - "A" + 8'd10;
		end else if (c >= "a" && c <= "f") begin
			v = c - "a" + 8'd10;
		end else if (c >= "0" && c <= "9") begin
			v = c - "0";
		end
		return v[3:0];
	endfunction

	// Advance the predictor by one accepted item and queue the bytes it makes.
	function automatic void decode_byte(input logic [1:0] k, input logic [7:0] c,
			input logic lst);
		logic [7:0] made[4];
		int         n_made;
		int         slot;
		int         i;
		n_made = 0;
		if (k != KIND_ESCAPE) begin
			// copy/drop/spare byte abandons any escape in flight
			esc_phase = PH_NORMAL;
			if (k == KIND_COPY) begin
				made[n_made] = c;
				n_made += 1;
			end
		end else if (esc_phase == PH_NORMAL) begin
			// a backslash at the token end is just a character
			if (c == CH_BACKSLASH && !lst) begin
				esc_phase = PH_BACKSLASH;
			end else begin
				made[n_made] = c;
				n_made += 1;
			end
		end else if (esc_phase == PH_BACKSLASH) begin
			if (c == CH_U) begin
				esc_phase = PH_HEX0;
				cp_acc = 16'h0000;
			end else begin
				made[n_made] = unescape_char(c);
				n_made += 1;
				esc_phase = PH_NORMAL;
			end
		end else begin
			slot = int'(esc_phase) - int'(PH_HEX0);
			if (slot > 3) begin
				slot = 3;
			end
			cp_acc = {cp_acc[11:0], hex_digit(c)};
			if (slot == 3) begin
				// fourth digit: encode as UTF-8, no surrogate pairing
				if (cp_acc < 16'h0080) begin
					made[n_made] = cp_acc[7:0];
					n_made += 1;
				end else if (cp_acc < 16'h0800) begin
					made[n_made] = {3'b110, cp_acc[10:6]};
					made[n_made + 1] = {2'b10, cp_acc[5:0]};
					n_made += 2;
				end else begin
					made[n_made] = {4'b1110, cp_acc[15:12]};
					made[n_made + 1] = {2'b10, cp_acc[11:6]};
					made[n_made + 2] = {2'b10, cp_acc[5:0]};
					n_made += 3;
				end
				esc_phase = PH_NORMAL;
			end else begin
				digit_buf[slot] = c;
				esc_phase = esc_phase + 3'd1;
				if (lst) begin
					// cut-short \u: replay held digits as plain escaped text
					i = 0;
					while (i <= slot) begin
						if (digit_buf[i] != CH_BACKSLASH || i + 1 > slot) begin
							made[n_made] = digit_buf[i];
							n_made += 1;
							i++;
						end else begin
							if (digit_buf[i + 1] != CH_U) begin
								made[n_made] = unescape_char(digit_buf[i + 1]);
								n_made += 1;
							end
							i += 2;
						end
					end
				end
			end
		end
		if (lst) begin
			esc_phase = PH_NORMAL;
		end
		for (i = 0; i < n_made; i++) begin
			decoded_due.push_back('{data: made[i], run_end: (i == n_made - 1)});
		end
	endfunction

	task automatic push_item(input logic [1:0] k, input logic [7:0] b, input logic e);
		raw_feed.push_back('{kind: k, data: b, tok_end: e});
	endtask

	task automatic push_token(input logic [1:0] k, input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_item(k, s[i], i == s.len() - 1);
		end
	endtask

	// hex digit character, random letter case, now and then garbage
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if ($urandom_range(0, 15) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		if (v < 4'd10) begin
			return "0" + 8'(v);
		end
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
	endfunction

	// One random token: mostly well-formed escape text, sometimes cut short,
	// sometimes another mode, sometimes a mode flip in the middle.
	task automatic gen_token(inout int fed);
		logic [7:0]  tok[$];
		logic [1:0]  k;
		logic [1:0]  ik;
		logic [15:0] cp;
		string       esc_set;
		int          roll;
		int          cut;
		esc_set = "\"\\/bfnrtuqz";
		roll = $urandom_range(0, 9);
		k = (roll < 7) ? KIND_ESCAPE : (roll == 7) ? KIND_COPY :
			(roll == 8) ? KIND_DROP : KIND_SPARE;
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 3))
				0: tok.push_back(8'($urandom_range(0, 255)));
				1: begin
					tok.push_back(CH_BACKSLASH);
					if ($urandom_range(0, 3) == 0) begin
						tok.push_back(8'($urandom_range(0, 255)));
					end else begin
						tok.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
					end
				end
				default: begin
					case ($urandom_range(0, 2))
						0:       cp = 16'($urandom_range(0, 16'h007F));
						1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
						default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
					endcase
					tok.push_back(CH_BACKSLASH);
					tok.push_back(CH_U);
					for (int d = 3; d >= 0; d--) begin
						tok.push_back(hex_char(cp[d*4 +: 4]));
					end
				end
			endcase
		end
		if ($urandom_range(0, 3) == 0) begin
			cut = $urandom_range(1, tok.size());
			while (tok.size() > cut) begin
				void'(tok.pop_back());
			end
		end
		foreach (tok[i]) begin
			ik = k;
			if (k == KIND_ESCAPE && $urandom_range(0, 19) == 0) begin
				ik = 2'($urandom_range(1, 3));
			end
			push_item(ik, tok[i], i == tok.size() - 1);
			fed++;
		end
	endtask

	// Driver: bursts of items with random gaps; prediction on acceptance.
	int        burst_left = 8;
	int        gap_left = 0;
	src_item_t next_item;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_byte(kind, in_byte, token_last);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (raw_feed.size() > 0) begin
					next_item = raw_feed.pop_front();
					in_valid <= 1'b1;
					kind <= next_item.kind;
					in_byte <= next_item.data;
					token_last <= next_item.tok_end;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall pattern switches among four styles, chosen by rx_cycle[6:5].
	logic [15:0] rx_cycle = 16'h0000;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 16'd1;
			case (rx_cycle[6:5])
				2'd0:    out_ready <= 1'b1;
				2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
				2'd2:    out_ready <= (rx_cycle % 3 == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
			if (out_valid && out_ready) begin
				if (decoded_due.size() == 0) begin
					flag_error($sformatf("unexpected byte %02h run_last=%0b",
						out_byte, run_last));
				end else begin
					if (out_byte !== decoded_due[0].data) begin
						flag_error($sformatf("out_byte %02h, want %02h",
							out_byte, decoded_due[0].data));
					end
					if (run_last !== decoded_due[0].run_end) begin
						flag_error($sformatf("run_last %0b, want %0b on byte %02h",
							run_last, decoded_due[0].run_end, decoded_due[0].data));
					end
					void'(decoded_due.pop_front());
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int fed;
		fed = 0;
		// field extremes, drop and the unused mode
		push_item(KIND_COPY, 8'h00, 1'b0);
		push_item(KIND_COPY, 8'hFF, 1'b1);
		push_item(KIND_DROP, 8'h80, 1'b0);
		push_item(KIND_SPARE, 8'h7F, 1'b1);
		// escaped quote, three-byte UTF-8, lone backslash at token end
		push_token(KIND_ESCAPE, "\\\"\\uFFFF\\");
		// newline escape and an unknown escape
		push_token(KIND_ESCAPE, "\\n\\z");
		// \u cut short after two digits: the digits come out raw
		push_token(KIND_ESCAPE, "\\u00");
		// backslash-u right at the token end emits nothing
		push_token(KIND_ESCAPE, "\\u");
		// copy byte lands in the middle of an escape
		push_item(KIND_ESCAPE, CH_BACKSLASH, 1'b0);
		push_item(KIND_COPY, "q", 1'b1);
		while (fed < RandomItems) begin
			gen_token(fed);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (raw_feed.size() != 0 || in_valid || decoded_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(posedge clk);
		if (decoded_due.size() != 0) begin
			flag_error($sformatf("%0d decoded bytes never arrived", decoded_due.size()));
		end
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TIMEOUT @%0t", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule
